>>> hw/rtl/pcdp_pkg.sv
// Package for the packed codebook dot product: widths, register indexes,
// shared types and the helper that unpacks one codebook index.
// Used by every other file of the block; depends on nothing.
package pcdp_pkg;

  localparam int VALUE_WIDTH  = 16;
  localparam int SUM_WIDTH    = 48;
  localparam int CB_WIDTH     = 16;
  localparam int CB_ENTRIES   = 16;
  localparam int CB_WORDS     = 4;
  localparam int CB_REG_WIDTH = 64;
  localparam int GROUP_SIZE   = 8;
  localparam int CODES_WIDTH  = 32;
  localparam int INDEX_WIDTH  = 4;
  localparam int MODE_WIDTH   = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int PIPE_DEPTH   = 5;

  localparam int PROD_WIDTH   = VALUE_WIDTH + CB_WIDTH;
  localparam int PAIR_WIDTH   = PROD_WIDTH + 1;
  localparam int QUAD_WIDTH   = PROD_WIDTH + 2;
  localparam int GROUP_WIDTH  = PROD_WIDTH + 3;
  localparam int ACC_WIDTH    = SUM_WIDTH + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_BITS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CB_A      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CB_B      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CB_C      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CB_D      = 3'd4;

  // Index widths selected by code_bits; any other value works as four bits.
  localparam logic [MODE_WIDTH-1:0] CODE_BITS_2 = 3'd2;
  localparam logic [MODE_WIDTH-1:0] CODE_BITS_3 = 3'd3;
  localparam logic [MODE_WIDTH-1:0] CODE_BITS_4 = 3'd4;

  localparam logic [INDEX_WIDTH-1:0] IDX_MASK_2 = 4'h3;
  localparam logic [INDEX_WIDTH-1:0] IDX_MASK_3 = 4'h7;
  localparam logic [INDEX_WIDTH-1:0] IDX_MASK_4 = 4'hF;

  typedef logic [CB_ENTRIES-1:0][CB_WIDTH-1:0]     cb_t;
  typedef logic [GROUP_SIZE-1:0][PROD_WIDTH-1:0]   prod_arr_t;

  typedef struct packed {
    logic adv;     // pipeline advances this cycle
    logic accept;  // a word is taken this cycle
    logic last;    // the word taken closes a vector
  } merge_ctrl_t;

  typedef struct packed {
    logic                        valid;
    logic signed [SUM_WIDTH-1:0] sum;
  } res_t;

  // Returns index k of the group. The used bytes form one bitstream with
  // byte 0 most significant, and indices are read from its top downwards.
  function automatic logic [INDEX_WIDTH-1:0] code_index(
      input logic [CODES_WIDTH-1:0] codes,
      input logic [MODE_WIDTH-1:0]  mode,
      input int                     k);
    logic [CODES_WIDTH-1:0] s2;
    logic [CODES_WIDTH-1:0] s3;
    logic [CODES_WIDTH-1:0] s4;
    logic [INDEX_WIDTH-1:0] idx;
    s2 = {16'h0, codes[7:0], codes[15:8]};
    s3 = {8'h0, codes[7:0], codes[15:8], codes[23:16]};
    s4 = {codes[7:0], codes[15:8], codes[23:16], codes[31:24]};
    unique case (mode)
      CODE_BITS_2: idx = INDEX_WIDTH'(s2 >> (2 * GROUP_SIZE - 2 * (k + 1))) & IDX_MASK_2;
      CODE_BITS_3: idx = INDEX_WIDTH'(s3 >> (3 * GROUP_SIZE - 3 * (k + 1))) & IDX_MASK_3;
      default:     idx = INDEX_WIDTH'(s4 >> (4 * GROUP_SIZE - 4 * (k + 1))) & IDX_MASK_4;
    endcase
    return idx;
  endfunction

  // Clamps a sum that is one bit wider than the accumulator.
  function automatic logic signed [SUM_WIDTH-1:0] sat_sum(
      input logic signed [ACC_WIDTH-1:0] x);
    logic signed [SUM_WIDTH-1:0] r;
    if (x[ACC_WIDTH-1] != x[ACC_WIDTH-2]) begin
      r = {x[ACC_WIDTH-1], {(SUM_WIDTH-1){~x[ACC_WIDTH-1]}}};
    end else begin
      r = x[SUM_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pcdp_in_if.sv
// Input channel of the packed codebook dot product: one group per word.
// Depends on pcdp_pkg for the field widths.
interface pcdp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_0;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_1;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_2;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_3;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_4;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_5;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_6;
  logic signed [pcdp_pkg::VALUE_WIDTH-1:0]  query_7;
  logic        [pcdp_pkg::CODES_WIDTH-1:0]  packed_codes;
  logic                                     last_group;

  modport source (
    output valid, query_0, query_1, query_2, query_3, query_4, query_5, query_6,
           query_7, packed_codes, last_group,
    input  ready
  );
  modport sink (
    input  valid, query_0, query_1, query_2, query_3, query_4, query_5, query_6,
           query_7, packed_codes, last_group,
    output ready
  );
endinterface

>>> hw/rtl/pcdp_out_if.sv
// Output channel of the packed codebook dot product: one sum per word.
// Depends on pcdp_pkg for the sum width.
interface pcdp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]  dot_sum;

  modport source (output valid, dot_sum, input ready);
  modport sink   (input valid, dot_sum, output ready);
endinterface

>>> hw/rtl/pcdp_cfg_if.sv
// Configuration write channel of the packed codebook dot product.
// Depends on pcdp_pkg for the index and data widths.
interface pcdp_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [pcdp_pkg::CFG_INDEX_W-1:0]      index;
  logic [pcdp_pkg::CB_REG_WIDTH-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pcdp_lane.sv
// One multiply lane: codebook look-up, operand register and product register.
// Depends on pcdp_pkg.
module pcdp_lane (
  input  logic                                   clk_i,
  input  logic                                   adv_i,
  input  logic signed [pcdp_pkg::VALUE_WIDTH-1:0] query_i,
  input  logic [pcdp_pkg::INDEX_WIDTH-1:0]       index_i,
  input  pcdp_pkg::cb_t                          codebook_i,
  output logic signed [pcdp_pkg::PROD_WIDTH-1:0] product_o
);

  logic signed [pcdp_pkg::VALUE_WIDTH-1:0] query_q;
  logic signed [pcdp_pkg::CB_WIDTH-1:0]    entry_q;
  logic signed [pcdp_pkg::PROD_WIDTH-1:0]  product_q;

  // Operands are registered with the word; the product register takes their product when the pipeline next advances.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      query_q   <= query_i;
      entry_q   <= signed'(codebook_i[index_i]);
      product_q <= query_q * entry_q;
    end
  end

  assign product_o = product_q;

endmodule

>>> hw/rtl/pcdp_merge.sv
// Merging stage: registered adder tree over the lane products, saturating
// accumulator and the valid/last pipeline. Depends on pcdp_pkg.
module pcdp_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcdp_pkg::merge_ctrl_t ctrl_i,
  input  pcdp_pkg::prod_arr_t   products_i,
  output pcdp_pkg::res_t        res_o
);

  localparam int Pairs = pcdp_pkg::GROUP_SIZE / 2;
  localparam int Quads = pcdp_pkg::GROUP_SIZE / 4;

  logic [pcdp_pkg::PIPE_DEPTH-1:0]            valid_q;
  logic [pcdp_pkg::PIPE_DEPTH-1:0]            last_q;
  logic signed [pcdp_pkg::PAIR_WIDTH-1:0]     pair_q [Pairs];
  logic signed [pcdp_pkg::QUAD_WIDTH-1:0]     quad_q [Quads];
  logic signed [pcdp_pkg::GROUP_WIDTH-1:0]    group_q;
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]      acc_q;
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]      acc_d;
  logic signed [pcdp_pkg::ACC_WIDTH-1:0]      acc_wide;
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]      acc_sat;
  logic                                       group_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      last_q  <= '0;
    end else if (ctrl_i.adv) begin
      valid_q <= {valid_q[pcdp_pkg::PIPE_DEPTH-2:0], ctrl_i.accept};
      last_q  <= {last_q[pcdp_pkg::PIPE_DEPTH-2:0], ctrl_i.last};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      for (int i = 0; i < Pairs; i++) begin
        pair_q[i] <= pcdp_pkg::PAIR_WIDTH'(signed'(products_i[2*i]))
                   + pcdp_pkg::PAIR_WIDTH'(signed'(products_i[2*i+1]));
      end
      for (int i = 0; i < Quads; i++) begin
        quad_q[i] <= pcdp_pkg::QUAD_WIDTH'(pair_q[2*i])
                   + pcdp_pkg::QUAD_WIDTH'(pair_q[2*i+1]);
      end
      group_q <= pcdp_pkg::GROUP_WIDTH'(quad_q[0]) + pcdp_pkg::GROUP_WIDTH'(quad_q[1]);
    end
  end

  // The group sum cannot leave the accumulator range, so only the running
  // total needs the clamp.
  assign group_done = ctrl_i.adv & valid_q[pcdp_pkg::PIPE_DEPTH-1];
  assign acc_wide   = pcdp_pkg::ACC_WIDTH'(acc_q) + pcdp_pkg::ACC_WIDTH'(group_q);
  assign acc_sat    = pcdp_pkg::sat_sum(acc_wide);

  always_comb begin
    acc_d = acc_q;
    if (group_done) begin
      acc_d = last_q[pcdp_pkg::PIPE_DEPTH-1] ? '0 : acc_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign res_o.valid = group_done & last_q[pcdp_pkg::PIPE_DEPTH-1];
  assign res_o.sum   = acc_sat;

  // A delivered total always leaves a cleared accumulator behind.
  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> acc_q == '0)
    else $error("accumulator not cleared after a result");

  // While the pipeline is held the running total must not move.
  a_acc_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.adv |=> $stable(acc_q))
    else $error("accumulator changed during a stall");

endmodule

>>> hw/rtl/packed_codebook_dot_product.sv
// Top level of the packed codebook dot product: configuration registers,
// index unpacking, eight lanes, merging stage and the output skid buffer.
// Depends on pcdp_pkg, the pcdp_*_if interfaces, pcdp_lane and pcdp_merge.

// The block takes one word per clock cycle while the skid word is free, each
// word holding eight Q1.15 query values and their packed 2-, 3- or 4-bit
// codebook indices, and keeps a saturating Q18.30 running sum in 48 bits. A
// word marked as the last group yields one output word with the total,
// including that group, and clears the sum. Sustained throughput is one word
// per cycle while the skid word stays free, set by the eight parallel multiply
// lanes and the registered accumulate loop. A result reaches the output after
// its closing word has passed operand capture, multiply, two levels of pair
// sums, the group sum and the accumulate into the output register. The output
// has a register and a skid word behind it, so in_i.ready depends only on
// whether the skid word is occupied and never on out_o.ready in the same
// cycle; when the skid word fills, the whole pipeline holds. Configuration is
// taken at any time (ready is always high) but should only be written while
// no vector is in flight: index 0 sets the index width (2, 3, anything else
// means 4), indexes 1 to 4 hold codebook entries 0-3, 4-7, 8-11 and 12-15,
// entry 0 in the low bits, and writes to other indexes are ignored.
module packed_codebook_dot_product (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcdp_in_if.sink     in_i,
  pcdp_out_if.source  out_o,
  pcdp_cfg_if.sink    cfg_i
);

  logic [pcdp_pkg::MODE_WIDTH-1:0]                            code_bits_q;
  logic [pcdp_pkg::CB_WORDS-1:0][pcdp_pkg::CB_REG_WIDTH-1:0]  cb_words_q;
  pcdp_pkg::cb_t                                              codebook;

  logic signed [pcdp_pkg::VALUE_WIDTH-1:0] query [pcdp_pkg::GROUP_SIZE];
  pcdp_pkg::prod_arr_t                     products;
  pcdp_pkg::merge_ctrl_t                   ctrl;
  pcdp_pkg::res_t                          res;

  logic                                    adv;
  logic                                    out_valid_q, out_valid_d;
  logic                                    skid_valid_q, skid_valid_d;
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]   out_sum_q, out_sum_d;
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]   skid_sum_q, skid_sum_d;
  logic                                    out_take;

  // Configuration registers. The port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= pcdp_pkg::CODE_BITS_4;
      cb_words_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index) inside
        pcdp_pkg::REG_CODE_BITS: begin
          code_bits_q <= cfg_i.data[pcdp_pkg::MODE_WIDTH-1:0];
        end
        pcdp_pkg::REG_CB_A, pcdp_pkg::REG_CB_B, pcdp_pkg::REG_CB_C,
        pcdp_pkg::REG_CB_D: begin
          cb_words_q[2'(cfg_i.index - pcdp_pkg::REG_CB_A)] <= cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  assign codebook = pcdp_pkg::cb_t'(cb_words_q);

  // The pipeline moves whenever the skid word is free.
  assign adv        = ~skid_valid_q;
  assign in_i.ready = adv;

  assign ctrl.adv    = adv;
  assign ctrl.accept = in_i.valid & adv;
  assign ctrl.last   = in_i.last_group;

  assign query[0] = in_i.query_0;
  assign query[1] = in_i.query_1;
  assign query[2] = in_i.query_2;
  assign query[3] = in_i.query_3;
  assign query[4] = in_i.query_4;
  assign query[5] = in_i.query_5;
  assign query[6] = in_i.query_6;
  assign query[7] = in_i.query_7;

  for (genvar k = 0; k < pcdp_pkg::GROUP_SIZE; k++) begin : g_lane
    logic [pcdp_pkg::INDEX_WIDTH-1:0]       index;
    logic signed [pcdp_pkg::PROD_WIDTH-1:0] product;

    assign index = pcdp_pkg::code_index(in_i.packed_codes, code_bits_q, k);

    pcdp_lane u_lane (
      .clk_i      (clk_i),
      .adv_i      (adv),
      .query_i    (query[k]),
      .index_i    (index),
      .codebook_i (codebook),
      .product_o  (product)
    );

    assign products[k] = product;
  end

  pcdp_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .products_i (products),
    .res_o      (res)
  );

  // Output register with one skid word behind it. A new total goes straight
  // to the output register when that is free or being taken, else it waits
  // in the skid word, which refills the output register on the next take.
  assign out_take = out_valid_q & out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_sum_d    = out_sum_q;
    skid_valid_d = skid_valid_q;
    skid_sum_d   = skid_sum_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_sum_d    = skid_sum_q;
        skid_valid_d = 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        out_sum_d   = res.sum;
      end else begin
        skid_valid_d = 1'b1;
        skid_sum_d   = res.sum;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q  <= out_sum_d;
    skid_sum_q <= skid_sum_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.dot_sum = out_sum_q;

  // The skid word is only ever filled behind an occupied output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word holds a total while the output register is empty");

  // The merging stage must never deliver a total while the skid word is full.
  a_no_result_on_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !skid_valid_q)
    else $error("total produced while the skid word is occupied");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for packed_codebook_dot_product: drives groups and
// register writes, predicts every dot_sum word and compares it on arrival.
// Depends on pcdp_pkg and the pcdp_in_if, pcdp_out_if and pcdp_cfg_if interfaces.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RESET_CYCLES       = 10;
  localparam int     QUIET_LIMIT        = 2000;
  localparam int     MAX_GAP            = 60;
  localparam int     SETTLE_CYCLES      = pcdp_pkg::PIPE_DEPTH + 3;
  localparam int     ENTRIES_PER_WORD   = pcdp_pkg::CB_ENTRIES / pcdp_pkg::CB_WORDS;
  localparam int     BIG_GROUPS         = 8;
  localparam int     WORDS_PER_SETTING  = 212;
  localparam longint SUM_HI             = (64'sd1 <<< (pcdp_pkg::SUM_WIDTH - 1)) - 1;
  localparam longint SUM_LO             = -SUM_HI - 1;

  localparam logic signed [pcdp_pkg::VALUE_WIDTH-1:0] QUERY_MAX =
    {1'b0, {(pcdp_pkg::VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [pcdp_pkg::VALUE_WIDTH-1:0] QUERY_MIN =
    {1'b1, {(pcdp_pkg::VALUE_WIDTH-1){1'b0}}};

  // One input word: a group of eight query values, its packed indices and
  // the flag that closes the vector.
  typedef struct {
    logic signed [pcdp_pkg::VALUE_WIDTH-1:0] query [pcdp_pkg::GROUP_SIZE];
    logic [pcdp_pkg::CODES_WIDTH-1:0]        codes;
    logic                                    last;
  } group_t;

  typedef logic [pcdp_pkg::CB_REG_WIDTH-1:0] cb_regs_t [pcdp_pkg::CB_WORDS];

  logic clk_i;
  logic rst_ni;

  pcdp_in_if  in_ch ();
  pcdp_out_if out_ch ();
  pcdp_cfg_if cfg_ch ();

  packed_codebook_dot_product dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Our own copy of the configuration and the running sum. They follow the
  // words the block has actually accepted, so they move at handshake time.
  logic [pcdp_pkg::MODE_WIDTH-1:0]          cfg_code_bits;
  logic [pcdp_pkg::CB_REG_WIDTH-1:0]        cfg_codebook [pcdp_pkg::CB_WORDS];
  longint                                   running_total;
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]    expected_sums [$];
  logic signed [pcdp_pkg::SUM_WIDTH-1:0]    oldest_sum;

  int error_count;
  int src_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;

  // Free-running clock, period 4 ns.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic longint clamp_sum(input longint v);
    if (v > SUM_HI) begin
      return SUM_HI;
    end
    if (v < SUM_LO) begin
      return SUM_LO;
    end
    return v;
  endfunction

  // Reads the index of one lane bit by bit. The used bytes form a single
  // stream, byte 0 first and each byte taken from its top bit down, so
  // stream bit p lives in byte p/8 at bit position 7 - p%8.
  function automatic logic [pcdp_pkg::INDEX_WIDTH-1:0] lane_index(
      input logic [pcdp_pkg::CODES_WIDTH-1:0] codes,
      input int                               bits,
      input int                               lane);
    logic [pcdp_pkg::INDEX_WIDTH-1:0] idx;
    int                               pos;
    idx = '0;
    for (int b = 0; b < bits; b++) begin
      pos = bits * lane + b;
      idx = {idx[pcdp_pkg::INDEX_WIDTH-2:0], codes[8 * (pos / 8) + 7 - pos % 8]};
    end
    return idx;
  endfunction

  // Folds one accepted group into the running sum. A closing group queues
  // the total it produces and clears the sum for the next vector.
  task automatic absorb_group(input group_t g);
    int                                    bits;
    logic [pcdp_pkg::INDEX_WIDTH-1:0]      idx;
    logic signed [pcdp_pkg::CB_WIDTH-1:0]  entry;
    longint                                group_sum;
    // Any code_bits value other than two or three behaves as four.
    bits = (cfg_code_bits == pcdp_pkg::CODE_BITS_2) ? 2 :
           (cfg_code_bits == pcdp_pkg::CODE_BITS_3) ? 3 : 4;
    group_sum = 0;
    for (int k = 0; k < pcdp_pkg::GROUP_SIZE; k++) begin
      idx = lane_index(g.codes, bits, k);
      entry = cfg_codebook[idx / ENTRIES_PER_WORD]
                          [pcdp_pkg::CB_WIDTH * (idx % ENTRIES_PER_WORD) +: pcdp_pkg::CB_WIDTH];
      group_sum = clamp_sum(group_sum + longint'(g.query[k]) * longint'(entry));
    end
    running_total = clamp_sum(running_total + group_sum);
    if (g.last) begin
      expected_sums.push_back(running_total[pcdp_pkg::SUM_WIDTH-1:0]);
      running_total = 0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Every word leaving the block is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected dot_sum word %0d", out_ch.dot_sum));
      end else begin
        oldest_sum = expected_sums.pop_front();
        if (out_ch.dot_sum !== oldest_sum) begin
          report_mismatch($sformatf("dot_sum is %0d, predicted %0d",
                                    out_ch.dot_sum, oldest_sum));
        end
      end
    end
  end

  // Watchdog: any stretch without a single handshake on any channel that
  // lasts this long means the block has hung.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side back-pressure. It is the only process that drives the
  // output ready, which starts low and then follows the stall percentage.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offers one group, after a random idle gap when the sender is set to
  // idle, and returns at the edge where the block takes it. Valid is left
  // high so that a following word can go out back to back.
  task automatic send_group(input group_t g);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.query_0      <= g.query[0];
    in_ch.query_1      <= g.query[1];
    in_ch.query_2      <= g.query[2];
    in_ch.query_3      <= g.query[3];
    in_ch.query_4      <= g.query[4];
    in_ch.query_5      <= g.query[5];
    in_ch.query_6      <= g.query[6];
    in_ch.query_7      <= g.query[7];
    in_ch.packed_codes <= g.codes;
    in_ch.last_group   <= g.last;
    do @(posedge clk_i); while (!in_ch.ready);
    absorb_group(g);
  endtask

  // Stops sending, waits for every predicted sum to come out and then lets
  // the pipeline run dry, so that open groups cannot meet a register write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_sums.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write. Only indexes 0 to 4 exist; the rest are dropped.
  task automatic write_reg(input logic [pcdp_pkg::CFG_INDEX_W-1:0] index,
                           input logic [pcdp_pkg::CB_REG_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (index)
      pcdp_pkg::REG_CODE_BITS: cfg_code_bits   = data[pcdp_pkg::MODE_WIDTH-1:0];
      pcdp_pkg::REG_CB_A:      cfg_codebook[0] = data;
      pcdp_pkg::REG_CB_B:      cfg_codebook[1] = data;
      pcdp_pkg::REG_CB_C:      cfg_codebook[2] = data;
      pcdp_pkg::REG_CB_D:      cfg_codebook[3] = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_codebook(input cb_regs_t regs);
    write_reg(pcdp_pkg::REG_CB_A, regs[0]);
    write_reg(pcdp_pkg::REG_CB_B, regs[1]);
    write_reg(pcdp_pkg::REG_CB_C, regs[2]);
    write_reg(pcdp_pkg::REG_CB_D, regs[3]);
  endtask

  // Even lanes take qa and odd lanes qb.
  function automatic group_t pattern_group(
      input logic signed [pcdp_pkg::VALUE_WIDTH-1:0] qa,
      input logic signed [pcdp_pkg::VALUE_WIDTH-1:0] qb,
      input logic [pcdp_pkg::CODES_WIDTH-1:0]        codes,
      input logic                                    last);
    group_t g;
    for (int k = 0; k < pcdp_pkg::GROUP_SIZE; k++) begin
      g.query[k] = (k % 2 == 0) ? qa : qb;
    end
    g.codes = codes;
    g.last  = last;
    return g;
  endfunction

  // Random query values lean towards the extremes now and then; the index
  // bytes are fully random, including the bytes a narrow mode ignores.
  function automatic group_t random_group(input logic last);
    group_t g;
    for (int k = 0; k < pcdp_pkg::GROUP_SIZE; k++) begin
      case ($urandom_range(15))
        0:       g.query[k] = QUERY_MAX;
        1:       g.query[k] = QUERY_MIN;
        2:       g.query[k] = '0;
        3:       g.query[k] = '1;
        default: g.query[k] = pcdp_pkg::VALUE_WIDTH'($urandom);
      endcase
    end
    g.codes = $urandom;
    g.last  = last;
    return g;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Straight after reset the codebook is all zeros in four-bit mode, so a
  // two-group vector must sum to zero whatever the queries are.
  task automatic test_reset_state();
    send_group(pattern_group(QUERY_MAX, QUERY_MIN, $urandom, 1'b0));
    send_group(pattern_group(QUERY_MIN, QUERY_MAX, $urandom, 1'b1));
    settle();
  endtask

  // Loads sixteen distinct entries, with entries eight to fifteen non-zero
  // so that a narrow mode reaching them would show, then walks through every
  // code_bits value, the unlisted ones included. The first word's bytes hold
  // ascending indices for the three-bit layout and a junk top byte;
  // the second reaches the upper half of the table in four-bit mode.
  task automatic test_index_modes();
    cb_regs_t regs;
    regs[0] = {16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000};
    regs[1] = {16'hC000, 16'h4000, 16'hEDCB, 16'h1234};
    regs[2] = {16'h0F0F, 16'hA5A5, 16'h5A5A, 16'hF0F0};
    regs[3] = {16'h8001, 16'h7FFE, 16'h0100, 16'hFF00};
    write_codebook(regs);
    for (int m = 0; m < 2 ** pcdp_pkg::MODE_WIDTH; m++) begin
      write_reg(pcdp_pkg::REG_CODE_BITS, pcdp_pkg::CB_REG_WIDTH'(m));
      send_group(pattern_group(QUERY_MAX, QUERY_MIN, 32'hC677_3905, 1'b0));
      send_group(pattern_group(QUERY_MIN, QUERY_MAX, 32'hEFCD_AB89, 1'b1));
      settle();
    end
  endtask

  // Writes to indexes beyond the last register must change nothing.
  task automatic test_ignored_writes();
    write_reg(pcdp_pkg::REG_CODE_BITS, pcdp_pkg::CB_REG_WIDTH'(pcdp_pkg::CODE_BITS_3));
    for (int r = pcdp_pkg::REG_CB_D + 1; r < 2 ** pcdp_pkg::CFG_INDEX_W; r++) begin
      write_reg(pcdp_pkg::CFG_INDEX_W'(r), '1);
    end
    send_group(pattern_group(QUERY_MAX, QUERY_MAX, 32'h0000_0000, 1'b0));
    send_group(pattern_group(QUERY_MIN, QUERY_MAX, 32'hFFFF_FFFF, 1'b1));
    settle();
  endtask

  // Feeds the largest groups of both signs back to back. Every entry is the
  // most negative value, so all-minimum queries add 2^33 per group and
  // all-maximum queries take almost as much away. The rails themselves lie
  // 16384 such groups away, so this covers the widest sums short of them.
  task automatic test_large_sums();
    cb_regs_t regs;
    for (int r = 0; r < pcdp_pkg::CB_WORDS; r++) begin
      regs[r] = {ENTRIES_PER_WORD{QUERY_MIN}};
    end
    write_codebook(regs);
    for (int i = 0; i < BIG_GROUPS; i++) begin
      send_group(pattern_group(QUERY_MIN, QUERY_MIN, $urandom, 1'b0));
    end
    for (int i = 0; i < 4; i++) begin
      send_group(pattern_group(QUERY_MAX, QUERY_MAX, $urandom, i == 3));
    end
    for (int i = 0; i < BIG_GROUPS; i++) begin
      send_group(pattern_group(QUERY_MAX, QUERY_MAX, $urandom, 1'b0));
    end
    send_group(pattern_group(QUERY_MAX, QUERY_MAX, $urandom, 1'b1));
    settle();
  endtask

  // Random vectors under four idling regimes, two register settings each,
  // eight settings in all so that every code_bits value is used. Codebooks
  // cycle through random contents, the extremes, all entries -1, and random contents with entries 0 to 3 zero.
  task automatic test_random_vectors();
    cb_regs_t regs;
    int       setting;
    int       sent;
    int       len;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      for (int s = 0; s < 2; s++) begin
        setting = 2 * p + s;
        for (int r = 0; r < pcdp_pkg::CB_WORDS; r++) begin
          case (setting % 4)
            0: regs[r] = {$urandom, $urandom};
            1: regs[r] = {(ENTRIES_PER_WORD / 2){QUERY_MAX, QUERY_MIN}};
            2: regs[r] = '1;
            default: regs[r] = (r == 0) ? '0 : {$urandom, $urandom};
          endcase
        end
        write_reg(pcdp_pkg::REG_CODE_BITS, pcdp_pkg::CB_REG_WIDTH'(setting));
        write_codebook(regs);
        sent = 0;
        while (sent < WORDS_PER_SETTING) begin
          // Mostly short vectors, with the odd long one.
          len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          for (int i = 0; i < len; i++) begin
            send_group(random_group(i == len - 1));
          end
          sent += len;
        end
        settle();
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    error_count    = 0;
    quiet_cycles   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    running_total  = 0;
    cfg_code_bits  = pcdp_pkg::CODE_BITS_4;
    for (int r = 0; r < pcdp_pkg::CB_WORDS; r++) begin
      cfg_codebook[r] = '0;
    end

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.query_0      = '0;
    in_ch.query_1      = '0;
    in_ch.query_2      = '0;
    in_ch.query_3      = '0;
    in_ch.query_4      = '0;
    in_ch.query_5      = '0;
    in_ch.query_6      = '0;
    in_ch.query_7      = '0;
    in_ch.packed_codes = '0;
    in_ch.last_group   = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = pcdp_pkg::REG_CODE_BITS;
    cfg_ch.data        = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_index_modes();
    test_ignored_writes();
    test_large_sums();
    test_random_vectors();

    // Everything has been sent; settle() has already waited for the last
    // sums, so anything still queued here is a missing word.
    settle();
    if (expected_sums.size() != 0) begin
      report_mismatch($sformatf("%0d dot_sum words never arrived", expected_sums.size()));
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
